/* src/pti_pkg.sv */
// Shared types and constants of the piecewise table interpolator.
`default_nettype none
package pti_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = 7;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_VALUE = 2'd1;
    localparam logic [1:0] ACT_DERIV = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_CUBIC_MODE  = 2'd1;
    localparam logic [1:0] REG_EXTRAPOLATE = 2'd2;

    // Datapath operations, one per controller step.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LATCH  = 4'd1;  // capture item, issue read of slot 0
    localparam logic [3:0] OP_RDPREV = 4'd2;  // issue read of slot k-1 for a load
    localparam logic [3:0] OP_LOAD   = 4'd3;  // compare order, write slot
    localparam logic [3:0] OP_RDHI   = 4'd4;  // issue read of last knot
    localparam logic [3:0] OP_BOUNDS = 4'd5;  // capture lo/hi, classify
    localparam logic [3:0] OP_SCAN   = 4'd6;  // issue read of scan slot j+1
    localparam logic [3:0] OP_TEST   = 4'd7;  // test interval j
    localparam logic [3:0] OP_FETCH  = 4'd8;  // capture operands of chosen interval
    localparam logic [3:0] OP_MUL    = 4'd9;  // product = operand * dx
    localparam logic [3:0] OP_ACC    = 4'd10; // accumulate, saturate
    localparam logic [3:0] OP_FINISH = 4'd11; // place result in output register
    localparam logic [3:0] OP_RDIV   = 4'd12; // issue read of chosen interval

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] step;
    } pti_cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_eval;
        logic in_range;   // strictly between first and last knot
        logic use_poly;   // interval math needed
        logic found;      // scan located the interval
        logic scan_last;  // scan reached the final interval
        logic out_busy;   // output register still holds a beat
    } pti_stat_t;
endpackage
`default_nettype wire

/* src/pti_stream_if.sv */
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none
interface pti_in_if;
    import pti_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  point_index;
    logic signed [31:0] position;
    logic signed [31:0] point_value;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    modport source (output valid, action, point_index, position, point_value,
                    coef_b, coef_c, coef_d, input ready);
    modport sink (input valid, action, point_index, position, point_value,
                  coef_b, coef_c, coef_d, output ready);
endinterface

interface pti_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [1:0]  status;
    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

interface pti_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/pti_ctrl.sv */
// Controller state machine that sequences loads, searches and Horner steps.
`default_nettype none
module pti_ctrl
    import pti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic cubic,
    input  wire logic deriv,
    input  wire pti_stat_t stat,
    output logic      idle,
    output pti_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_PREV   = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_HI     = 4'd4;
    localparam logic [3:0] S_BOUNDS = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_TEST   = 4'd7;
    localparam logic [3:0] S_FETCH  = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_ACC    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_GRAB   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] last_step;

    // Cubic value runs three multiply steps, cubic slope two, linear value one.
    always_comb
    begin
        if (!cubic)
            last_step = 2'd0;
        else if (deriv)
            last_step = 2'd1;
        else
            last_step = 2'd2;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_load)
                    state_next = S_PREV;
                else if (stat.is_eval)
                    state_next = S_HI;
                else
                    state_next = S_DONE;
            end
            S_PREV:
            begin
                cmd.op = OP_RDPREV;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.op = OP_LOAD;
                state_next = S_DONE;
            end
            S_HI:
            begin
                cmd.op = OP_RDHI;
                state_next = S_BOUNDS;
            end
            S_BOUNDS:
            begin
                cmd.op = OP_BOUNDS;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!stat.in_range)
                    state_next = stat.use_poly ? S_FETCH : S_DONE;
                else
                begin
                    cmd.op = OP_SCAN;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                cmd.op = OP_TEST;
                state_next = (stat.found || stat.scan_last) ? S_FETCH : S_SCAN;
            end
            S_FETCH:
            begin
                cmd.op = OP_RDIV;
                state_next = S_GRAB;
            end
            // The table read issued in the previous cycle is now registered.
            S_GRAB:
            begin
                cmd.op = OP_FETCH;
                step_next = 2'd0;
                state_next = (cubic || !deriv) ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (step_reg == last_step)
                    state_next = S_DONE;
                else
                begin
                    step_next = step_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

`ifndef SYNTH
    a_latch_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == S_IDLE)
        else $error("item accepted while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> step_reg <= last_step)
        else $error("Horner step overran");
    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINISH |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
`endif
endmodule
`default_nettype wire

/* src/pti_datapath.sv */
// Table memory, interval search registers, multiplier and saturating accumulator.
`default_nettype none
module pti_datapath
    import pti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pti_cmd_t cmd,
    input  wire logic [1:0]  in_action,
    input  wire logic [5:0]  in_index,
    input  wire logic signed [31:0] in_position,
    input  wire logic signed [31:0] in_value,
    input  wire logic signed [31:0] in_b,
    input  wire logic signed [31:0] in_c,
    input  wire logic signed [31:0] in_d,
    input  wire logic [CNT_W-1:0] point_count,
    input  wire logic cubic,
    input  wire logic extrap,
    input  wire logic out_ready,
    output logic      deriv,
    output pti_stat_t stat,
    output logic      out_valid,
    output logic signed [31:0] out_result,
    output logic [1:0] out_status
);
    localparam int ENT_W = 160;
    localparam int CIDX_W = IDX_W + 1;
    logic [ENT_W-1:0] table_mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    logic [1:0]  act_reg;
    logic [5:0]  idx_reg;
    logic signed [31:0] x_reg, val_reg, b_reg, c_reg, d_reg;
    logic signed [31:0] lo_reg, flo_reg;
    logic signed [31:0] prev_pos_reg;
    logic [IDX_W-1:0] j_reg, id_reg;
    logic in_range_reg, use_reg, found_reg;
    logic signed [32:0] dx_reg;
    logic signed [31:0] f_reg, fb_reg, fc_reg, fd_reg;
    logic signed [31:0] acc_reg;
    logic signed [64:0] prod_reg;
    logic sat_reg, order_reg;
    logic out_valid_reg;
    logic signed [31:0] out_result_reg;
    logic [1:0] out_status_reg;

    logic [CIDX_W-1:0] n_live;
    logic [IDX_W-1:0]  last_idx, last_iv;
    logic signed [31:0] rd_pos, rd_val, rd_b, rd_c, rd_d;
    logic signed [31:0] mul_op, add_op, acc_sum_sat;
    logic acc_ovf;
    logic signed [48:0] prod_fl;
    logic [IDX_W-1:0] jn;

    always_comb
    begin
        if (point_count < CNT_W'(2))
            n_live = CIDX_W'(2);
        else if (point_count > CNT_W'(MAX_POINTS))
            n_live = CIDX_W'(MAX_POINTS);
        else
            n_live = point_count[CIDX_W-1:0];
    end
    assign last_idx = IDX_W'(n_live - CIDX_W'(1));
    assign last_iv  = IDX_W'(n_live - CIDX_W'(2));
    assign jn = j_reg + IDX_W'(1);

    assign rd_pos = rd_data_reg[159:128];
    assign rd_val = rd_data_reg[127:96];
    assign rd_b   = rd_data_reg[95:64];
    assign rd_c   = rd_data_reg[63:32];
    assign rd_d   = rd_data_reg[31:0];

    always_comb
    begin
        rd_en = 1'b1;
        case (cmd.op)
            OP_LATCH:  rd_addr = '0;
            OP_RDPREV: rd_addr = IDX_W'(idx_reg - 6'd1);
            OP_RDHI:   rd_addr = last_idx;
            OP_SCAN:   rd_addr = jn;
            OP_RDIV:   rd_addr = id_reg;
            default:
            begin
                rd_addr = '0;
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
            table_mem[idx_reg[IDX_W-1:0]] <= {x_reg, val_reg, b_reg, c_reg, d_reg};
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    // Horner operand selection per step.
    always_comb
    begin
        if (!cubic)
        begin
            mul_op = fb_reg;
            add_op = f_reg;
        end
        else
        begin
            case (cmd.step)
                2'd0:    mul_op = fd_reg;
                default: mul_op = acc_reg;
            endcase
            if (deriv)
                add_op = (cmd.step == 2'd0) ? fc_reg : fb_reg;
            else
            begin
                case (cmd.step)
                    2'd0:    add_op = fc_reg;
                    2'd1:    add_op = fb_reg;
                    default: add_op = f_reg;
                endcase
            end
        end
    end

    // Arithmetic shift gives the floor of the product over 65536.
    assign prod_fl = prod_reg[64:16];

    always_comb
    begin
        logic signed [50:0] wide;
        if (cubic && deriv && cmd.step == 2'd0)
            wide = 51'(prod_fl) * 51'sd3 + 51'(add_op) * 51'sd2;
        else
            wide = 51'(prod_fl) + 51'(add_op);
        acc_ovf = 1'b0;
        if (wide > 51'sh7FFFFFFF)
        begin
            acc_sum_sat = 32'sh7FFFFFFF;
            acc_ovf = 1'b1;
        end
        else if (wide < -51'sh80000000)
        begin
            acc_sum_sat = -32'sh80000000;
            acc_ovf = 1'b1;
        end
        else
            acc_sum_sat = wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                act_reg <= in_action;
                idx_reg <= in_index;
                x_reg <= in_position;
                val_reg <= in_value;
                b_reg <= in_b;
                c_reg <= in_c;
                d_reg <= in_d;
                sat_reg <= 1'b0;
                order_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            OP_RDPREV:
            begin
                prev_pos_reg <= rd_pos;
            end
            OP_LOAD:
            begin
                order_reg <= (idx_reg != 6'd0) && (x_reg <= rd_pos);
            end
            OP_RDHI:
            begin
                lo_reg <= rd_pos;
                flo_reg <= rd_val;
            end
            OP_BOUNDS:
            begin
                in_range_reg <= (lo_reg < x_reg) && (x_reg < rd_pos);
                use_reg <= extrap || ((lo_reg < x_reg) && (x_reg < rd_pos));
                j_reg <= '0;
                if (x_reg <= lo_reg)
                begin
                    id_reg <= '0;
                    acc_reg <= (act_reg == ACT_DERIV) ? 32'sd0 : flo_reg;
                end
                else
                begin
                    id_reg <= last_iv;
                    acc_reg <= (act_reg == ACT_DERIV) ? 32'sd0 : rd_val;
                end
                prev_pos_reg <= lo_reg;
            end
            OP_SCAN:
            begin
            end
            OP_TEST:
            begin
                // prev_pos_reg holds pos[j], the registered read holds pos[j+1].
                if (prev_pos_reg <= x_reg && x_reg <= rd_pos)
                begin
                    found_reg <= 1'b1;
                    id_reg <= j_reg;
                end
                prev_pos_reg <= rd_pos;
                j_reg <= jn;
            end
            OP_FETCH:
            begin
                dx_reg <= 33'(x_reg) - 33'(rd_pos);
                f_reg <= rd_val;
                fb_reg <= rd_b;
                fc_reg <= rd_c;
                fd_reg <= rd_d;
                if (!cubic && deriv)
                    acc_reg <= rd_b;
            end
            OP_MUL:
            begin
                prod_reg <= 65'(mul_op) * 65'(dx_reg);
            end
            OP_ACC:
            begin
                acc_reg <= acc_sum_sat;
                if (acc_ovf)
                    sat_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign deriv = (act_reg == ACT_DERIV);
    assign stat.is_load = (act_reg == ACT_LOAD) && ({1'b0, idx_reg} < 7'(MAX_POINTS));
    assign stat.is_eval = (act_reg == ACT_VALUE) || (act_reg == ACT_DERIV);
    assign stat.in_range = in_range_reg && !found_reg;
    assign stat.use_poly = use_reg;
    assign stat.found = (prev_pos_reg <= x_reg) && (x_reg <= rd_pos);
    assign stat.scan_last = (j_reg == last_iv);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FINISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            if (stat.is_eval)
            begin
                out_result_reg <= acc_reg;
                out_status_reg <= sat_reg ? ST_SAT : ST_OK;
            end
            else
            begin
                out_result_reg <= '0;
                out_status_reg <= (stat.is_load && order_reg) ? ST_ORDER : ST_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_status = out_status_reg;

`ifndef SYNTH
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg != 2'd3)
        else $error("illegal status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_result_reg))
        else $error("result lost under stall");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_TEST |-> j_reg <= last_iv)
        else $error("scan ran past the table");
`endif
endmodule
`default_nettype wire

/* src/piecewise_table_interpolator.sv */
// Top level of the piecewise table interpolator.
// One item is handled at a time. A load reads the previous slot for the order
// check and writes its slot before the output beat. An evaluation reads the
// end knots, then scans intervals one at a time through the single table
// read port, and is followed by up to three multiply and accumulate steps.
// Results sit in an output register, so the next item is taken once the
// controller returns to idle even if the result is not yet taken.
`default_nettype none
module piecewise_table_interpolator
    import pti_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pti_in_if.sink    item,
    pti_out_if.source result,
    pti_cfg_if.sink   cfg
);
    logic [CNT_W-1:0] point_count_reg;
    logic cubic_reg, extrap_reg;
    logic idle, in_fire, deriv;
    pti_cmd_t cmd;
    pti_stat_t stat;

    assign item.ready = idle;
    assign in_fire = item.valid && idle;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CNT_W'(2);
            cubic_reg <= 1'b0;
            extrap_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POINT_COUNT: point_count_reg <= cfg.data[CNT_W-1:0];
                REG_CUBIC_MODE:  cubic_reg <= cfg.data[0];
                REG_EXTRAPOLATE: extrap_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    pti_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .cubic(cubic_reg),
        .deriv(deriv), .stat(stat), .idle(idle), .cmd(cmd)
    );

    pti_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_action(item.action), .in_index(item.point_index),
        .in_position(item.position), .in_value(item.point_value),
        .in_b(item.coef_b), .in_c(item.coef_c), .in_d(item.coef_d),
        .point_count(point_count_reg), .cubic(cubic_reg), .extrap(extrap_reg),
        .out_ready(result.ready), .deriv(deriv), .stat(stat),
        .out_valid(result.valid), .out_result(result.result_value),
        .out_status(result.status)
    );
endmodule
`default_nettype wire

/* verif/pti_tb_pkg.sv */
// Types shared by the testbench modules of the piecewise table interpolator.
package pti_tb_pkg;
    import pti_pkg::*;

    typedef struct {
        logic [1:0]         action;
        logic [5:0]         point_index;
        logic signed [31:0] position;
        logic signed [31:0] point_value;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
    } query_item_t;

    typedef struct {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } interp_result_t;
endpackage

/* verif/tb_piecewise_table_interpolator.sv */
// Self-checking testbench of the piecewise table interpolator with a built-in predictor.
module tb_piecewise_table_interpolator
    import pti_pkg::*, pti_tb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pti_in_if  item_ch();
    pti_out_if result_ch();
    pti_cfg_if cfg_ch();

    piecewise_table_interpolator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic signed [31:0] knot_pos [MAX_POINTS];
    logic signed [31:0] knot_val [MAX_POINTS];
    logic signed [31:0] slope_b [MAX_POINTS];
    logic signed [31:0] curve_c [MAX_POINTS];
    logic signed [31:0] curve_d [MAX_POINTS];
    logic [6:0] cur_count;
    logic       cur_cubic;
    logic       cur_extrap;
    int         loaded_slots;

    interp_result_t expected_q [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;

    logic       hold_off_result = 1'b0;
    logic       no_idling = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic longint floor_q16(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp32(input longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic interp_result_t interpolate(input query_item_t it);
        interp_result_t r;
        int n;
        int id;
        logic use_poly;
        logic sat;
        logic deriv;
        longint dx, f, b, c, d, dd, u, t1, t2, res;
        res = 0;
        sat = 1'b0;
        r.status = ST_OK;
        if (it.action == ACT_LOAD) begin
            if (it.point_index > 0 && it.position <= knot_pos[it.point_index - 1])
                r.status = ST_ORDER;
            knot_pos[it.point_index] = it.position;
            knot_val[it.point_index] = it.point_value;
            slope_b[it.point_index] = it.coef_b;
            curve_c[it.point_index] = it.coef_c;
            curve_d[it.point_index] = it.coef_d;
        end else if (it.action == ACT_VALUE || it.action == ACT_DERIV) begin
            deriv = (it.action == ACT_DERIV);
            n = (cur_count < 2) ? 2 : ((cur_count > MAX_POINTS) ? MAX_POINTS : cur_count);
            id = n - 2;
            use_poly = 1'b1;
            if (knot_pos[0] < it.position && it.position < knot_pos[n - 1]) begin
                for (int j = 0; j + 1 < n; j++) begin
                    if (knot_pos[j] <= it.position && it.position <= knot_pos[j + 1]) begin
                        id = j;
                        break;
                    end
                end
            end else if (it.position <= knot_pos[0]) begin
                id = 0;
                if (!cur_extrap) begin
                    use_poly = 1'b0;
                    res = deriv ? 0 : longint'(knot_val[0]);
                end
            end else if (!cur_extrap) begin
                use_poly = 1'b0;
                res = deriv ? 0 : longint'(knot_val[n - 1]);
            end
            if (use_poly) begin
                dx = longint'(it.position) - longint'(knot_pos[id]);
                f = knot_val[id];
                b = slope_b[id];
                c = curve_c[id];
                d = curve_d[id];
                if (cur_cubic) begin
                    dd = floor_q16(d * dx);
                    if (deriv) begin
                        u = clamp32(2 * c + 3 * dd, sat);
                        res = clamp32(b + floor_q16(u * dx), sat);
                    end else begin
                        t1 = clamp32(c + dd, sat);
                        t2 = clamp32(b + floor_q16(t1 * dx), sat);
                        res = clamp32(f + floor_q16(t2 * dx), sat);
                    end
                end else if (deriv) begin
                    res = b;
                end else begin
                    res = clamp32(f + floor_q16(b * dx), sat);
                end
            end
            if (sat)
                r.status = ST_SAT;
        end
        r.result_value = res[31:0];
        return r;
    endfunction

    // Inputs change on the falling edge.
    task automatic send_item(input query_item_t it);
        @(negedge clk);
        while (!no_idling && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8)) @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.action <= it.action;
        item_ch.point_index <= it.point_index;
        item_ch.position <= it.position;
        item_ch.point_value <= it.point_value;
        item_ch.coef_b <= it.coef_b;
        item_ch.coef_c <= it.coef_c;
        item_ch.coef_d <= it.coef_d;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_q = {expected_q, interpolate(it)};
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    // Directed rows that carry a typed-in result check it before queuing.
    task automatic send_checked(input query_item_t it, input logic has_want,
                                input interp_result_t want);
        interp_result_t p;
        p = interpolate_peek(it);
        if (has_want && (p.result_value !== want.result_value || p.status !== want.status))
            report_mismatch("directed table", {p.status, p.result_value[29:0]},
                            {want.status, want.result_value[29:0]});
        send_item(it);
    endtask

    // Predicts without updating the table (evaluations do not change state).
    function automatic interp_result_t interpolate_peek(input query_item_t it);
        interp_result_t r;
        logic signed [31:0] prev;
        if (it.action == ACT_LOAD) begin
            r.result_value = '0;
            prev = (it.point_index > 0) ? knot_pos[it.point_index - 1] : '0;
            r.status = (it.point_index > 0 && it.position <= prev) ? ST_ORDER : ST_OK;
            return r;
        end
        return interpolate(it);
    endfunction

    task automatic wait_drained();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_POINT_COUNT: cur_count = val[6:0];
            REG_CUBIC_MODE:  cur_cubic = val[0];
            REG_EXTRAPOLATE: cur_extrap = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] small_coef();
        return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endfunction

    // Fills n slots with increasing positions and random content.
    task automatic load_table(input int n, input logic wild);
        query_item_t it;
        logic signed [31:0] p;
        p = $signed($urandom_range(0, 32'h40000)) - 32'sh7fff0000;
        for (int k = 0; k < n; k++) begin
            it.action = ACT_LOAD;
            it.point_index = k[5:0];
            it.position = p;
            it.point_value = wild ? rand_word() : small_coef();
            it.coef_b = wild ? rand_word() : small_coef();
            it.coef_c = wild ? rand_word() : small_coef();
            it.coef_d = wild ? rand_word() : small_coef();
            send_item(it);
            p = p + $signed($urandom_range(1, 32'h3ffffff / n));
        end
        if (n > loaded_slots)
            loaded_slots = n;
    endtask

    function automatic query_item_t rand_query(input int n);
        query_item_t it;
        int k;
        it.action = $urandom_range(0, 1) ? ACT_VALUE : ACT_DERIV;
        it.point_index = 6'($urandom());
        it.point_value = $urandom();
        it.coef_b = $urandom();
        it.coef_c = $urandom();
        it.coef_d = $urandom();
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: it.position = knot_pos[k];
            1: it.position = $urandom();
            2: it.position = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: it.position = knot_pos[k] + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
        endcase
        return it;
    endfunction

    // Result side: random stall bursts, and a long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n || hold_off_result)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0 && !no_idling) begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk) begin
        interp_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", result_ch.result_value, '0);
            end else begin
                want = expected_q.pop_front();
                if (result_ch.result_value !== want.result_value)
                    report_mismatch("result_value", result_ch.result_value,
                                    want.result_value);
                if (result_ch.status !== want.status)
                    report_mismatch("status", {30'd0, result_ch.status},
                                    {30'd0, want.status});
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n || hold_off_result)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    typedef struct {
        query_item_t    it;
        logic           has_want;
        interp_result_t want;
    } directed_row_t;

    initial begin
        directed_row_t rows [$];
        directed_row_t row;
        int n;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD;
        item_ch.point_index = '0;
        item_ch.position = '0;
        item_ch.point_value = '0;
        item_ch.coef_b = '0;
        item_ch.coef_c = '0;
        item_ch.coef_d = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_POINT_COUNT;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
        cur_count = 7'd2;
        cur_cubic = 1'b0;
        cur_extrap = 1'b0;
        loaded_slots = 0;
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            knot_pos[k] = '0;
            knot_val[k] = '0;
            slope_b[k] = '0;
            curve_c[k] = '0;
            curve_d[k] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: two-point table at the extremes, then queries.
        row.has_want = 1'b1;
        row.it = '{ACT_LOAD, 6'd0, 32'sh80000000, 32'sh00010000, 32'sh00020000, 32'sd0, 32'sd0};
        row.want = '{32'sd0, ST_OK};
        rows = {rows, row};
        row.it = '{ACT_LOAD, 6'd1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff};
        row.want = '{32'sd0, ST_ORDER};
        rows = {rows, row};
        row.it = '{ACT_LOAD, 6'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff};
        row.want = '{32'sd0, ST_OK};
        rows = {rows, row};
        row.it = '{ACT_VALUE, 6'd63, 32'sh80000000, '1, '1, '1, '1};
        row.want = '{32'sh00010000, ST_OK};
        rows = {rows, row};
        row.it = '{ACT_DERIV, 6'd0, 32'sh80000000, 0, 0, 0, 0};
        row.want = '{32'sd0, ST_OK};
        rows = {rows, row};
        row.it = '{ACT_VALUE, 6'd0, 32'sh7fffffff, 0, 0, 0, 0};
        row.want = '{32'sh7fffffff, ST_OK};
        rows = {rows, row};
        row.has_want = 1'b0;
        row.it = '{ACT_VALUE, 6'd0, 32'sd0, 0, 0, 0, 0};
        rows = {rows, row};
        row.it = '{ACT_DERIV, 6'd0, 32'sd0, 0, 0, 0, 0};
        rows = {rows, row};
        row.has_want = 1'b1;
        row.it = '{2'd3, 6'd5, 32'sh12345678, '1, '1, '1, '1};
        row.want = '{32'sd0, ST_OK};
        rows = {rows, row};
        foreach (rows[i])
            send_checked(rows[i].it, rows[i].has_want, rows[i].want);
        loaded_slots = 2;
        wait_drained();

        // Cubic and extrapolation on the extreme table exercise saturation.
        write_reg(REG_CUBIC_MODE, 32'd1);
        write_reg(REG_EXTRAPOLATE, 32'd1);
        foreach (rows[i])
            if (rows[i].it.action != ACT_LOAD)
                send_item(rows[i].it);
        wait_drained();

        // Random phases across settings, the extremes among them.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: n = 2;
                1: n = MAX_POINTS;
                2: n = 3;
                default: n = $urandom_range(2, 16);
            endcase
            if (phase == 11)
                no_idling = 1'b1;
            write_reg(REG_POINT_COUNT, n);
            write_reg(REG_CUBIC_MODE, phase % 2);
            write_reg(REG_EXTRAPOLATE, (phase / 2) % 2);
            load_table(n, phase % 3 == 0);
            if (phase == 4) begin
                // Receiver stalls long while items keep coming.
                fork
                    begin
                        hold_off_result = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off_result = 1'b0;
                    end
                join_none
            end
            for (int q = 0; q < 110; q++) begin
                if ($urandom_range(0, 19) == 0) begin
                    query_item_t ld;
                    // Occasional out-of-order reload of a live slot.
                    ld = rand_query(n);
                    ld.action = ACT_LOAD;
                    ld.point_index = 6'($urandom_range(0, n - 1));
                    send_item(ld);
                end else begin
                    send_item(rand_query(n));
                end
                if (q == 55)
                    wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
